FILE: design/rc5d_pkg.sv
// Shared types, constants and helpers for the RC5-32 block decryption pipeline.
`default_nettype none

package rc5d_pkg;

  localparam int WORD_W  = 32;
  localparam int BLOCK_W = 2 * WORD_W;
  localparam int IDX_W   = 5;
  localparam int ROT_W   = $clog2(WORD_W);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef struct packed {
    logic                op;
    logic [IDX_W-1:0]    key_index;
    logic [WORD_W-1:0]   key_word;
    logic [BLOCK_W-1:0]  cipher_block;
  } in_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] plain_block;
  } out_item_t;

  // Rotate right; an amount of zero leaves the word as it is.
  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] w,
                                             input logic [ROT_W-1:0]  n);
    logic [2*WORD_W-1:0] dbl;
    dbl  = {w, w} >> n;
    rotr = dbl[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/rc5d_in_if.sv
// Valid/ready channel carrying one input item of the decryption pipeline.
`default_nettype none

interface rc5d_in_if;
  import rc5d_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/rc5d_out_if.sv
// Valid/ready channel carrying one decrypted block.
`default_nettype none

interface rc5d_out_if;
  import rc5d_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/rc5_block_decrypt_top.sv
// RC5-32 decryption: one half-round per pipeline stage, plus a final key-whitening stage.
// Throughput: one item per cycle; the whole pipeline stalls only when the result is held.
// Key loads travel down the pipeline and update each stage's key word as they pass it,
// so blocks ahead of a load use the old key and blocks behind it use the new one.
// Reset clears the stage valid bits; key words are undefined until loaded.
`default_nettype none

module rc5_block_decrypt_top
  import rc5d_pkg::*;
#(
  parameter int ROUNDS = 12
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rc5d_in_if.sink    in_i,
  rc5d_out_if.source out_o
);

  localparam int TW = 2 * ROUNDS + 2;  // key table words
  localparam int NS = 2 * ROUNDS + 1;  // pipeline stages
  localparam int LS = NS - 1;          // whitening stage

  logic [WORD_W-1:0]  key_q [TW];

  logic               valid_q [NS];
  logic               dec_q   [NS];
  logic [BLOCK_W-1:0] data_q  [NS];

  // stage inputs
  logic               s_valid [NS];
  logic               s_dec   [NS];
  logic [BLOCK_W-1:0] s_data  [NS];
  logic [BLOCK_W-1:0] data_d  [NS];

  logic advance;

  assign out_o.valid            = valid_q[LS] & dec_q[LS];
  assign out_o.data.plain_block = data_q[LS];
  assign advance                = !(valid_q[LS] & dec_q[LS]) | out_o.ready;
  assign in_i.ready             = advance;

  // A load item carries its index and word in the block lanes.
  assign s_valid[0] = in_i.valid;
  assign s_dec[0]   = (in_i.data.op == OP_DECRYPT);
  assign s_data[0]  = (in_i.data.op == OP_DECRYPT) ? in_i.data.cipher_block :
                      {{(BLOCK_W-WORD_W-IDX_W){1'b0}}, in_i.data.key_index, in_i.data.key_word};

  for (genvar s = 1; s < NS; s++) begin : g_link
    assign s_valid[s] = valid_q[s-1];
    assign s_dec[s]   = dec_q[s-1];
    assign s_data[s]  = data_q[s-1];
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [WORD_W-1:0] a, b;
    assign a = s_data[s][BLOCK_W-1:WORD_W];
    assign b = s_data[s][WORD_W-1:0];

    if (s == LS) begin : g_white
      always_comb begin
        data_d[s] = s_data[s];
        if (s_dec[s]) begin
          data_d[s] = {a - key_q[0], b - key_q[1]};
        end
      end
    end else if ((s % 2) == 0) begin : g_half_b
      always_comb begin
        data_d[s] = s_data[s];
        if (s_dec[s]) begin
          data_d[s] = {a, rotr(b - key_q[TW-1-s], a[ROT_W-1:0]) ^ a};
        end
      end
    end else begin : g_half_a
      always_comb begin
        data_d[s] = s_data[s];
        if (s_dec[s]) begin
          data_d[s] = {rotr(a - key_q[TW-1-s], b[ROT_W-1:0]) ^ b, b};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
        dec_q[s]   <= 1'b0;
      end else if (advance) begin
        valid_q[s] <= s_valid[s];
        dec_q[s]   <= s_dec[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        data_q[s] <= data_d[s];
      end
    end
  end

  // Each key word is written when a load passes the stage that reads it.
  for (genvar k = 0; k < TW; k++) begin : g_key
    localparam int OWN = (k < 2) ? LS : (TW - 1 - k);
    logic hit;
    assign hit = advance && s_valid[OWN] && !s_dec[OWN] &&
                 ({{(32-IDX_W){1'b0}}, s_data[OWN][WORD_W +: IDX_W]} == 32'(k));

    always_ff @(posedge clk_i) begin
      if (hit) begin
        key_q[k] <= s_data[OWN][WORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
